// ===== design/ghbb_pkg.sv =====
`default_nettype none
package ghbb_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned TIME_W     = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_AIR_TEMP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HUMIDITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOIL_TARGET_PCT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_BAND       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUMID_BAND      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOIL_BAND       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_RUN_TIME   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_REST_TIME  = 3'd7;

  // Reset values of the configuration registers.
  localparam logic signed [11:0] RST_TARGET_AIR_TEMP = 12'sd250;
  localparam logic [9:0]         RST_TARGET_HUMIDITY = 10'd600;
  localparam logic [9:0]         RST_SOIL_TARGET_PCT = 10'd400;
  localparam logic [7:0]         RST_TEMP_BAND       = 8'd10;
  localparam logic [7:0]         RST_HUMID_BAND      = 8'd50;
  localparam logic [7:0]         RST_SOIL_BAND       = 8'd50;
  localparam logic [TIME_W-1:0]  RST_PUMP_RUN_TIME   = 32'd5000;
  localparam logic [TIME_W-1:0]  RST_PUMP_REST_TIME  = 32'd60000;

  // Item kinds.
  localparam logic ACTION_TICK     = 1'b0;
  localparam logic ACTION_SET_MODE = 1'b1;

  // Bit positions in the action vector.
  localparam int unsigned ACT_PUMP = 0;
  localparam int unsigned ACT_HEAT = 1;
  localparam int unsigned ACT_VENT = 2;

  typedef struct packed {
    logic               action;
    logic               mode_manual;
    logic [TIME_W-1:0]  now_ms;
    logic               soil_valid;
    logic [9:0]         soil_level;
    logic               climate_valid;
    logic signed [11:0] air_temp;
    logic [9:0]         air_humid;
  } in_item_t;

  typedef struct packed {
    logic pump_on;
    logic fan_on;
    logic heater_on;
    logic actions_changed;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/ghbb_in_if.sv =====
`default_nettype none
interface ghbb_in_if;
  logic               valid;
  logic               ready;
  ghbb_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/ghbb_out_if.sv =====
`default_nettype none
interface ghbb_out_if;
  logic                valid;
  logic                ready;
  ghbb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/greenhouse_bang_bang_controller_unit.sv =====
// A transaction accepted on in_if passes the input register and then the result register before its result is offered.
// Throughput: one transaction per cycle, set by the two-register pipeline (input register,
// result register) that stalls as a whole only while a result waits on out_if.
// Ticks in manual mode and set-mode requests to the current mode produce no result.
// Reset (synchronous, rst_n low) empties the pipeline, selects automatic mode, switches all
// drives off, clears the pump timers and loads the default configuration.
`default_nettype none
module greenhouse_bang_bang_controller_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  ghbb_in_if.sink                                  in_if,
  ghbb_out_if.source                               out_if,
  input  wire logic                                cfg_we,
  input  wire logic [ghbb_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [ghbb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic signed [11:0]              target_air_temp_r;
  logic [9:0]                      target_humidity_r;
  logic [9:0]                      soil_target_pct_r;
  logic [7:0]                      temp_band_r;
  logic [7:0]                      humid_band_r;
  logic [7:0]                      soil_band_r;
  logic [ghbb_pkg::TIME_W-1:0]     pump_run_time_r;
  logic [ghbb_pkg::TIME_W-1:0]     pump_rest_time_r;

  // Controller state.
  logic                            manual_mode_r, manual_mode_nxt;
  logic [2:0]                      act_r, act_nxt;
  logic [ghbb_pkg::TIME_W-1:0]     pump_start_r, pump_start_nxt;
  logic [ghbb_pkg::TIME_W-1:0]     rest_until_r, rest_until_nxt;

  // Pipeline registers.
  logic                            s1_valid_r;
  ghbb_pkg::in_item_t              s1_r;
  logic                            out_valid_r, out_valid_nxt;
  ghbb_pkg::out_item_t             out_r, out_nxt;

  logic                            advance;

  // The whole pipeline moves when the result register is free or being emptied. The input
  // register may also fill while it is empty, so a bubble never blocks the input side.
  assign advance      = !out_valid_r || out_if.ready;
  assign in_if.ready  = advance || !s1_valid_r;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  // Configuration writes. The user must write only while the block is idle; the block has no interlock to enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_air_temp_r <= ghbb_pkg::RST_TARGET_AIR_TEMP;
      target_humidity_r <= ghbb_pkg::RST_TARGET_HUMIDITY;
      soil_target_pct_r <= ghbb_pkg::RST_SOIL_TARGET_PCT;
      temp_band_r       <= ghbb_pkg::RST_TEMP_BAND;
      humid_band_r      <= ghbb_pkg::RST_HUMID_BAND;
      soil_band_r       <= ghbb_pkg::RST_SOIL_BAND;
      pump_run_time_r   <= ghbb_pkg::RST_PUMP_RUN_TIME;
      pump_rest_time_r  <= ghbb_pkg::RST_PUMP_REST_TIME;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ghbb_pkg::REG_TARGET_AIR_TEMP: target_air_temp_r <= $signed(cfg_data[11:0]);
        ghbb_pkg::REG_TARGET_HUMIDITY: target_humidity_r <= cfg_data[9:0];
        ghbb_pkg::REG_SOIL_TARGET_PCT: soil_target_pct_r <= cfg_data[9:0];
        ghbb_pkg::REG_TEMP_BAND:       temp_band_r       <= cfg_data[7:0];
        ghbb_pkg::REG_HUMID_BAND:      humid_band_r      <= cfg_data[7:0];
        ghbb_pkg::REG_SOIL_BAND:       soil_band_r       <= cfg_data[7:0];
        ghbb_pkg::REG_PUMP_RUN_TIME:   pump_run_time_r   <= cfg_data[ghbb_pkg::TIME_W-1:0];
        ghbb_pkg::REG_PUMP_REST_TIME:  pump_rest_time_r  <= cfg_data[ghbb_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: captures each accepted transaction unchanged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_r <= in_if.data;
    end
  end

  // Thresholds. The soil threshold is 11 bits signed and may go negative; the temperature
  // limits are 13 bits signed so that target plus or minus band never overflows.
  logic signed [10:0] soil_thr;
  logic signed [12:0] temp_lo, temp_hi, temp_tgt, temp_cur;
  logic [10:0]        humid_hi;
  logic               soil_low, too_cold, warm, too_hot, too_humid, fine;
  logic               run_done, rest_over;
  logic [ghbb_pkg::TIME_W-1:0] run_elapsed;

  always_comb begin
    soil_thr    = $signed({1'b0, soil_target_pct_r}) - $signed({3'b000, soil_band_r});
    soil_low    = $signed({1'b0, s1_r.soil_level}) < soil_thr;
    temp_tgt    = {target_air_temp_r[11], target_air_temp_r};
    temp_cur    = {s1_r.air_temp[11], s1_r.air_temp};
    temp_lo     = temp_tgt - $signed({5'b00000, temp_band_r});
    temp_hi     = temp_tgt + $signed({5'b00000, temp_band_r});
    humid_hi    = {1'b0, target_humidity_r} + {3'b000, humid_band_r};
    too_cold    = temp_cur <= temp_lo;
    warm        = temp_cur >= temp_tgt;
    too_hot     = temp_cur >= temp_hi;
    too_humid   = {1'b0, s1_r.air_humid} >= humid_hi;
    fine        = (temp_cur <= temp_tgt) && (s1_r.air_humid <= target_humidity_r);
    // Run time is measured modulo 2^32, while the end of the rest is a plain compare.
    run_elapsed = s1_r.now_ms - pump_start_r;
    run_done    = run_elapsed >= pump_run_time_r;
    rest_over   = s1_r.now_ms >= rest_until_r;
  end

  // Next state and result for the transaction in the input register.
  always_comb begin
    manual_mode_nxt = manual_mode_r;
    act_nxt         = act_r;
    pump_start_nxt  = pump_start_r;
    rest_until_nxt  = rest_until_r;
    out_valid_nxt   = 1'b0;

    if (s1_r.action == ghbb_pkg::ACTION_SET_MODE) begin
      // A change of mode in either direction switches every drive off.
      if (s1_r.mode_manual != manual_mode_r) begin
        manual_mode_nxt = s1_r.mode_manual;
        act_nxt         = '0;
        out_valid_nxt   = 1'b1;
      end
    end else if (!manual_mode_r) begin
      out_valid_nxt = 1'b1;

      if (act_r[ghbb_pkg::ACT_PUMP]) begin
        if (run_done) begin
          act_nxt[ghbb_pkg::ACT_PUMP] = 1'b0;
          rest_until_nxt              = s1_r.now_ms + pump_rest_time_r;
        end
      end else if (rest_over && s1_r.soil_valid && soil_low) begin
        act_nxt[ghbb_pkg::ACT_PUMP] = 1'b1;
        pump_start_nxt              = s1_r.now_ms;
      end

      // Heater and vent hold their state when the climate reading failed.
      if (s1_r.climate_valid) begin
        if (!act_r[ghbb_pkg::ACT_HEAT] && too_cold) begin
          act_nxt[ghbb_pkg::ACT_HEAT] = 1'b1;
        end else if (act_r[ghbb_pkg::ACT_HEAT] && warm) begin
          act_nxt[ghbb_pkg::ACT_HEAT] = 1'b0;
        end

        if (!act_r[ghbb_pkg::ACT_VENT] && (too_hot || too_humid)) begin
          act_nxt[ghbb_pkg::ACT_VENT] = 1'b1;
        end else if (act_r[ghbb_pkg::ACT_VENT] && fine) begin
          act_nxt[ghbb_pkg::ACT_VENT] = 1'b0;
        end
      end
    end

    out_nxt.pump_on         = act_nxt[ghbb_pkg::ACT_PUMP];
    out_nxt.fan_on          = act_nxt[ghbb_pkg::ACT_VENT];
    out_nxt.heater_on       = act_nxt[ghbb_pkg::ACT_HEAT];
    out_nxt.actions_changed = act_nxt != act_r;
  end

  // State and result register: updated only when the pipeline moves with a transaction
  // in the input register, so every transaction is applied exactly once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_mode_r <= 1'b0;
      act_r         <= '0;
      pump_start_r  <= '0;
      rest_until_r  <= '0;
      out_valid_r   <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && out_valid_nxt;
      if (s1_valid_r) begin
        manual_mode_r <= manual_mode_nxt;
        act_r         <= act_nxt;
        pump_start_r  <= pump_start_nxt;
        rest_until_r  <= rest_until_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && out_valid_nxt) begin
      out_r <= out_nxt;
    end
  end

  // Manual mode always runs with every drive off.
  a_manual_all_off: assert property (@(posedge clk) disable iff (!rst_n)
    manual_mode_r |-> (act_r == '0))
    else $error("drive active in manual mode");

  // A pending result always shows the current action state.
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.pump_on == act_r[ghbb_pkg::ACT_PUMP]) &&
                    (out_r.fan_on == act_r[ghbb_pkg::ACT_VENT]) &&
                    (out_r.heater_on == act_r[ghbb_pkg::ACT_HEAT]))
    else $error("result differs from action state");

  // A pump start records the time stamp of the transaction that started it.
  a_pump_start_time: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(act_r[ghbb_pkg::ACT_PUMP]) |-> (pump_start_r == $past(s1_r.now_ms)))
    else $error("pump start time not captured");

  // A stalled transaction stays in the input register.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("transaction lost while stalled");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ghbb_pkg::*;

  // One complete set of configuration register values. The whole set is
  // written in one go whenever the settings are changed.
  typedef struct {
    int          air_temp_tgt;
    int          humid_tgt;
    int          soil_tgt;
    int          t_band;
    int          h_band;
    int          s_band;
    logic [31:0] run_ms;
    logic [31:0] rest_ms;
  } cfg_set_t;

  // Tracks the controller's own view of the greenhouse: the mode, the three
  // drive bits, the pump timers and the current thresholds. Every accepted
  // input transaction that yields a result updates it and queues the drive
  // levels that the block should report.
  class climate_scoreboard;
    int          tgt_temp;
    int          tgt_humid;
    int          tgt_soil;
    int          band_temp;
    int          band_humid;
    int          band_soil;
    logic [31:0] run_ms;
    logic [31:0] rest_ms;
    logic        manual;
    logic [2:0]  acts;
    logic [31:0] pump_started;
    logic [31:0] rest_until;
    out_item_t   drive_q[$];
    int          fails;

    function new();
      tgt_temp     = RST_TARGET_AIR_TEMP;
      tgt_humid    = RST_TARGET_HUMIDITY;
      tgt_soil     = RST_SOIL_TARGET_PCT;
      band_temp    = RST_TEMP_BAND;
      band_humid   = RST_HUMID_BAND;
      band_soil    = RST_SOIL_BAND;
      run_ms       = RST_PUMP_RUN_TIME;
      rest_ms      = RST_PUMP_REST_TIME;
      manual       = 1'b0;
      acts         = '0;
      pump_started = '0;
      rest_until   = '0;
      fails        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TARGET_AIR_TEMP: tgt_temp   = $signed(val[11:0]);
        REG_TARGET_HUMIDITY: tgt_humid  = val[9:0];
        REG_SOIL_TARGET_PCT: tgt_soil   = val[9:0];
        REG_TEMP_BAND:       band_temp  = val[7:0];
        REG_HUMID_BAND:      band_humid = val[7:0];
        REG_SOIL_BAND:       band_soil  = val[7:0];
        REG_PUMP_RUN_TIME:   run_ms     = val;
        REG_PUMP_REST_TIME:  rest_ms    = val;
        default: ;
      endcase
    endfunction

    function void note_input(in_item_t it);
      logic [2:0]  prev;
      logic [31:0] elapsed;
      int          soil_i;
      int          temp_i;
      int          humid_i;
      bit          heating;
      bit          venting;
      bit          too_cold;
      bit          warm;
      bit          too_hot;
      bit          too_humid;
      bit          fine;
      out_item_t   want;
      prev = acts;
      if (it.action == ACTION_SET_MODE) begin
        // A request for the mode already in force is silently dropped.
        if (it.mode_manual == manual) return;
        manual = it.mode_manual;
        acts   = '0;
      end else begin
        if (manual) return;
        if (acts[ACT_PUMP]) begin
          elapsed = it.now_ms - pump_started;
          if (elapsed >= run_ms) begin
            acts[ACT_PUMP] = 1'b0;
            rest_until     = it.now_ms + rest_ms;
          end
        end else if (it.now_ms >= rest_until && it.soil_valid) begin
          soil_i = it.soil_level;
          if (soil_i < tgt_soil - band_soil) begin
            acts[ACT_PUMP] = 1'b1;
            pump_started   = it.now_ms;
          end
        end
        if (it.climate_valid) begin
          temp_i    = $signed(it.air_temp);
          humid_i   = it.air_humid;
          heating   = acts[ACT_HEAT];
          venting   = acts[ACT_VENT];
          too_cold  = temp_i <= tgt_temp - band_temp;
          warm      = temp_i >= tgt_temp;
          too_hot   = temp_i >= tgt_temp + band_temp;
          too_humid = humid_i >= tgt_humid + band_humid;
          fine      = temp_i <= tgt_temp && humid_i <= tgt_humid;
          if (!heating && too_cold) acts[ACT_HEAT] = 1'b1;
          else if (heating && warm) acts[ACT_HEAT] = 1'b0;
          if (!venting && (too_hot || too_humid)) acts[ACT_VENT] = 1'b1;
          else if (venting && fine) acts[ACT_VENT] = 1'b0;
        end
      end
      want.pump_on         = acts[ACT_PUMP];
      want.fan_on          = acts[ACT_VENT];
      want.heater_on       = acts[ACT_HEAT];
      want.actions_changed = (acts != prev);
      drive_q.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (drive_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result with nothing expected: pump=%0b fan=%0b heater=%0b changed=%0b",
                   $realtime, got.pump_on, got.fan_on, got.heater_on, got.actions_changed);
        return;
      end
      want = drive_q.pop_front();
      if (got.pump_on !== want.pump_on || got.fan_on !== want.fan_on ||
          got.heater_on !== want.heater_on ||
          got.actions_changed !== want.actions_changed) begin
        fails++;
        if (fails <= 10)
          $display({"%0t: drive mismatch: expected pump=%0b fan=%0b heater=%0b changed=%0b,",
                    " got pump=%0b fan=%0b heater=%0b changed=%0b"},
                   $realtime, want.pump_on, want.fan_on, want.heater_on, want.actions_changed,
                   got.pump_on, got.fan_on, got.heater_on, got.actions_changed);
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ghbb_in_if  in_ch();
  ghbb_out_if out_ch();

  climate_scoreboard sb = new();

  // When set, neither side idles: the sender offers back to back and the
  // result side stays ready, so the pipeline runs at full rate.
  bit          calm;
  int          stall_left;
  // Running millisecond clock used to build plausible tick sequences.
  logic [31:0] clock_ms;

  greenhouse_bang_bang_controller_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Both channels are observed at the rising edge. The block updates its
  // registers with nonblocking assignments, so the values seen here are the
  // ones that were present when the edge arrived. A result seen at this edge
  // always belongs to an earlier input transaction, so the order of the two
  // checks does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_input(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Values at the ends of a range turn up much more often than by chance.
  function automatic int pick_edge(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return lo;
    if (r < 4) return hi;
    return pick(lo, hi);
  endfunction

  function automatic logic [31:0] pick_ms();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 3) return '1;
    return $urandom_range(0, 3000);
  endfunction

  function automatic in_item_t tick(logic [31:0] now, logic sv, int soil, logic cv,
                                    int temp, int humid);
    in_item_t it;
    it               = '0;
    it.action        = ACTION_TICK;
    it.now_ms        = now;
    it.soil_valid    = sv;
    it.soil_level    = 10'(soil);
    it.climate_valid = cv;
    it.air_temp      = 12'(temp);
    it.air_humid     = 10'(humid);
    return it;
  endfunction

  function automatic in_item_t mode_req(logic to_manual);
    in_item_t it;
    it             = '0;
    it.action      = ACTION_SET_MODE;
    it.mode_manual = to_manual;
    it.now_ms      = $urandom;
    return it;
  endfunction

  // Builds one random input transaction. Most are ticks with a steadily
  // advancing clock and readings scattered around the current thresholds,
  // so that the hysteresis and the pump timing are exercised properly. A few
  // are mode changes, and a few are pure noise with every field random over
  // its full width.
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    int       mode_pct;
    r        = $urandom_range(0, 99);
    mode_pct = sb.manual ? 30 : 4;
    if (r < mode_pct) begin
      // From manual, mostly go back to automatic so little time is wasted.
      it = mode_req(sb.manual ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1)));
    end else if (r < mode_pct + 8) begin
      it.action        = 1'($urandom_range(0, 1));
      it.mode_manual   = 1'($urandom_range(0, 1));
      it.now_ms        = $urandom;
      it.soil_valid    = 1'($urandom_range(0, 1));
      it.soil_level    = 10'($urandom);
      it.climate_valid = 1'($urandom_range(0, 1));
      it.air_temp      = 12'($urandom);
      it.air_humid     = 10'($urandom);
    end else begin
      if ($urandom_range(0, 29) == 0) clock_ms += $urandom_range(0, 70000);
      else clock_ms += $urandom_range(0, 400);
      it = tick(clock_ms, $urandom_range(0, 9) != 0,
                clamp(sb.tgt_soil - sb.band_soil + pick(-60, 60), 0, 1000),
                $urandom_range(0, 9) != 0,
                clamp(sb.tgt_temp + pick(-sb.band_temp - 30, sb.band_temp + 30), -400, 1250),
                clamp(sb.tgt_humid + pick(-sb.band_humid - 30, sb.band_humid + 60), 0, 1000));
    end
    return it;
  endfunction

  function automatic cfg_set_t random_cfg();
    cfg_set_t c;
    c.air_temp_tgt = pick_edge(-400, 1250);
    c.humid_tgt    = pick_edge(0, 1000);
    c.soil_tgt     = pick_edge(0, 1000);
    c.t_band       = pick_edge(0, 200);
    c.h_band       = pick_edge(0, 200);
    c.s_band       = pick_edge(0, 200);
    c.run_ms       = pick_ms();
    c.rest_ms      = pick_ms();
    return c;
  endfunction

  // Offers one input transaction and returns at the falling edge after it
  // was accepted. Valid is left high so that a following transaction can go
  // straight out; whoever stops sending must lower it.
  task automatic send(in_item_t it);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected result has come out. Ticks
  // in manual mode leave nothing to wait for, so it then waits on to cover the
  // two-stage pipeline before the block is treated as idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    sb.set_reg(idx, val);
  endtask

  // Writes the whole register set on consecutive cycles; the write enable is
  // lowered only once, after the last register.
  task automatic program_regs(cfg_set_t c);
    put_reg(REG_TARGET_AIR_TEMP, 32'(c.air_temp_tgt));
    put_reg(REG_TARGET_HUMIDITY, 32'(c.humid_tgt));
    put_reg(REG_SOIL_TARGET_PCT, 32'(c.soil_tgt));
    put_reg(REG_TEMP_BAND, 32'(c.t_band));
    put_reg(REG_HUMID_BAND, 32'(c.h_band));
    put_reg(REG_SOIL_BAND, 32'(c.s_band));
    put_reg(REG_PUMP_RUN_TIME, c.run_ms);
    put_reg(REG_PUMP_REST_TIME, c.rest_ms);
    cfg_we <= 1'b0;
  endtask

  // The result side: ready drops for random stretches unless the phase is
  // a calm one.
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    cfg_set_t c;
    in_item_t it;
    int       useful;
    bit       ignored;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    calm        = 1'b0;
    clock_ms    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, run with the reset configuration: target 25.0 degrees
    // with a 1.0 degree band, 60.0 % humidity with a 5.0 % band, soil target
    // 40.0 % with a 5.0 % band, a 5 s pump run and a 60 s rest.
    // Cold, dry soil and very humid air switch all three drives on at once.
    send(tick(32'd0, 1'b1, 0, 1'b1, -400, 1000));
    // One millisecond short of the run time the pump keeps going; full heat
    // reaches the target, so the heater stops while the fan holds.
    send(tick(32'd4999, 1'b1, 0, 1'b1, 1250, 0));
    // The run time is up: the pump stops and the rest period begins. The air
    // is exactly at target, which lets the fan go off.
    send(tick(32'd5000, 1'b1, 0, 1'b1, 250, 600));
    // Still resting, so dry soil cannot restart the pump; the lower edge of
    // the temperature band switches the heater on.
    send(tick(32'd64999, 1'b1, 0, 1'b1, 240, 600));
    // Rest over, but the soil reading is flagged bad; humidity at the upper
    // edge of its band starts the fan.
    send(tick(32'd65000, 1'b0, 0, 1'b1, 249, 650));
    // A good soil reading just under the threshold starts the pump, while a
    // failed climate read leaves heater and fan as they are.
    send(tick(32'd65000, 1'b1, 349, 1'b0, 1250, 0));
    send(tick(32'd65100, 1'b1, 350, 1'b1, 250, 600));
    // Into manual mode: everything is switched off and reported.
    send(mode_req(1'b1));
    // Asking for the mode already in force, and a tick in manual, both pass
    // without a result.
    send(mode_req(1'b1));
    send(tick(32'd70000, 1'b1, 0, 1'b1, -400, 1000));
    // Back to automatic with nothing running: a result with no change.
    send(mode_req(1'b0));
    send(mode_req(1'b0));
    // A pump run started just before the clock wraps is timed across the
    // wrap and stops on the far side of it.
    send(tick(32'hFFFF_F000, 1'b1, 0, 1'b1, 260, 600));
    send(tick(32'h0000_0400, 1'b1, 1000, 1'b1, 250, 650));
    send(tick(32'h0000_0401, 1'b1, 0, 1'b1, 250, 600));
    // The cooldown end is compared as a plain unsigned number, so the top of
    // the clock range counts as past it.
    send(tick(32'hFFFF_FFFF, 1'b1, 0, 1'b1, 1250, 1000));
    send(tick(32'h0000_1387, 1'b1, 1000, 1'b1, -400, 0));
    send(tick(32'h0000_1388, 1'b1, 0, 1'b1, 0, 0));
    send(tick(32'h0000_1389, 1'b1, 1023, 1'b1, 2047, 1023));
    send(tick(32'h0000_138A, 1'b1, 0, 1'b1, -2048, 0));

    // Random phases, each with its own register set. The first three use
    // extreme settings: every target at its minimum but bands wide
    // open (so several thresholds go negative and the pump can never start),
    // everything at its maximum, and zero bands with zero pump times.
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      c = random_cfg();
      if (phase == 0) begin
        c = '{-400, 0, 0, 200, 200, 200, '0, '0};
      end else if (phase == 1) begin
        c = '{1250, 1000, 1000, 200, 200, 200, '1, '1};
      end else if (phase == 2) begin
        c.t_band  = 0;
        c.h_band  = 0;
        c.s_band  = 0;
        c.run_ms  = '0;
        c.rest_ms = '0;
      end
      program_regs(c);
      calm = (phase % 3 == 2);
      clock_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 60000)
                                             : $urandom;
      useful = 0;
      while (useful < 100) begin
        it = random_item();
        ignored = (it.action == ACTION_TICK && sb.manual) ||
                  (it.action == ACTION_SET_MODE && it.mode_manual == sb.manual);
        if (!ignored) useful++;
        send(it);
        // Every so often the sender holds back until the pipeline is empty.
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(negedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Guards against a hung handshake; a correct run ends long before this.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
design/ghbb_pkg.sv
design/ghbb_in_if.sv
design/ghbb_out_if.sv
design/greenhouse_bang_bang_controller_unit.sv
dv/tb.sv
